[rtl/core/srm_pkg.sv]
package srm_pkg;

    // sizes of the store
    localparam int SLOTS     = 8;
    localparam int ID_BITS   = 8;
    localparam int BODY_BITS = 64;

    localparam int PTR_BITS = $clog2(SLOTS + 1);
    localparam int IDX_BITS = $clog2(SLOTS);
    localparam int TAG_BITS = 2 * ID_BITS;

    // slot count as a pointer value; also the null link
    localparam logic [PTR_BITS-1:0] SLOT_CNT = PTR_BITS'(SLOTS);
    localparam logic [PTR_BITS-1:0] NIL      = SLOT_CNT;

    // stream layouts
    localparam int ACT_BITS      = 2;
    localparam int STATUS_BITS   = 3;
    localparam int IN_BODY_LSB   = TAG_BITS;
    localparam int IN_WT_BIT     = TAG_BITS + BODY_BITS;
    localparam int IN_WS_BIT     = IN_WT_BIT + 1;
    localparam int IN_DATA_BITS  = ((TAG_BITS + BODY_BITS + 2 + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((TAG_BITS + BODY_BITS + 7) / 8) * 8;
    localparam int OUT_USER_BITS = STATUS_BITS + 1;
    localparam int OUT_PAD_BITS  = OUT_DATA_BITS - TAG_BITS - BODY_BITS;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_DELIVER = 2'd0,
        ACT_RECEIVE = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_EXIT    = 2'd3
    } act_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_QUEUED   = 3'd0,
        ST_HANDED   = 3'd1,
        ST_FULL     = 3'd2,
        ST_RECEIVED = 3'd3,
        ST_WAITING  = 3'd4,
        ST_FAILED   = 3'd5,
        ST_NO_EFFECT = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        WAIT_NONE    = 2'd0,
        WAIT_PENDING = 2'd1,
        WAIT_FILLED  = 2'd2
    } wait_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_HANDOVER,
        OP_FULL,
        OP_ALLOC,
        OP_TAIL_STEP,
        OP_TAIL_LINK,
        OP_SCAN_START,
        OP_SCAN_STEP,
        OP_TAKE,
        OP_PEND,
        OP_CLEAR,
        OP_EXIT,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        act_t action;
        logic waiter_hit;
        logic free_empty;
        logic busy_empty;
        logic tail_done;
        logic scan_end;
        logic scan_hit;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/core/selective_receive_mailbox_unit.sv]
// channel  | direction | tdata (lowest bit up)                            | tuser
// ---------+-----------+--------------------------------------------------+----------------------
// s_axis   | in        | msg_type 8, sender 8, payload 64, any_type 1,    | action 2
//          |           | any_sender 1, zero pad 6                         |
// m_axis   | out       | out_type 8, out_sender 8, out_payload 64         | status 3, has_message 1
//
// one transaction is worked at a time: a handover, full, clear or sender-exit
// transaction and a deliver into an empty busy list go from the load step through
// the decide step to the emit step; a deliver that appends walks to the tail one
// slot a cycle and a receive scans the busy list one slot a cycle, both walking
// over the linked slots through the single read port
// s_axis_tready is high only while the controller is idle; a finished result
// sits in the output register, so the next transaction is taken while it waits
// a stalled result holds the controller in its emit step, no state is lost
// reset (rst_n low) chains every slot into the free list, empties the busy
// list and drops any pending receive; no clearing pass is needed
module selective_receive_mailbox_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // msg_type, sender, payload, any_type, any_sender, zero pad
    input  logic [srm_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    // action
    input  logic [srm_pkg::ACT_BITS-1:0]        s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_type, out_sender, out_payload
    output logic [srm_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    // status, has_message
    output logic [srm_pkg::OUT_USER_BITS-1:0]   m_axis_tuser
);

    // command from the controller, status back from the datapath
    srm_pkg::dp_op_t     dp_op;
    srm_pkg::dp_status_t dp_status;

    srm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (dp_status),
        .op       (dp_op)
    );

    // slot store, list pointers, pending filter and output register
    srm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (dp_op),
        .status    (dp_status),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule

[rtl/core/srm_datapath.sv]
module srm_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  srm_pkg::dp_op_t                        op,
    output srm_pkg::dp_status_t                    status,
    input  logic [srm_pkg::IN_DATA_BITS-1:0]       in_data,
    input  logic [srm_pkg::ACT_BITS-1:0]           in_user,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [srm_pkg::OUT_DATA_BITS-1:0]      out_data,
    output logic [srm_pkg::OUT_USER_BITS-1:0]      out_user
);

    // captured transaction
    srm_pkg::act_t                      act_reg, act_next;
    logic [srm_pkg::ID_BITS-1:0]        type_reg, type_next;
    logic [srm_pkg::ID_BITS-1:0]        snd_reg, snd_next;
    logic [srm_pkg::BODY_BITS-1:0]      body_reg, body_next;
    logic                               wt_reg, wt_next;
    logic                               ws_reg, ws_next;

    // list pointers and walk state
    logic [srm_pkg::PTR_BITS-1:0]       free_head_reg, free_head_next;
    logic [srm_pkg::PTR_BITS-1:0]       busy_head_reg, busy_head_next;
    logic [srm_pkg::PTR_BITS-1:0]       cur_reg, cur_next;
    logic [srm_pkg::PTR_BITS-1:0]       prev_reg, prev_next;
    logic [srm_pkg::PTR_BITS-1:0]       slot_reg, slot_next;
    logic [srm_pkg::PTR_BITS-1:0]       cnt_reg, cnt_next;

    // pending receive
    srm_pkg::wait_t                     wait_reg, wait_next;
    logic [srm_pkg::ID_BITS-1:0]        ftype_reg, ftype_next;
    logic [srm_pkg::ID_BITS-1:0]        fsnd_reg, fsnd_next;
    logic                               fwt_reg, fwt_next;
    logic                               fws_reg, fws_next;

    // slot store
    logic [srm_pkg::BODY_BITS-1:0]      slot_body_reg [srm_pkg::SLOTS];
    logic [srm_pkg::TAG_BITS-1:0]       slot_tag_reg [srm_pkg::SLOTS];
    logic [srm_pkg::PTR_BITS-1:0]       slot_link_reg [srm_pkg::SLOTS];
    logic [srm_pkg::PTR_BITS-1:0]       slot_link_next [srm_pkg::SLOTS];

    // result and output register
    srm_pkg::status_t                   res_status_reg, res_status_next;
    logic                               res_has_reg, res_has_next;
    logic [srm_pkg::ID_BITS-1:0]        res_type_reg, res_type_next;
    logic [srm_pkg::ID_BITS-1:0]        res_snd_reg, res_snd_next;
    logic [srm_pkg::BODY_BITS-1:0]      res_body_reg, res_body_next;

    logic                               out_valid_reg, out_valid_next;
    srm_pkg::status_t                   out_status_reg, out_status_next;
    logic                               out_has_reg, out_has_next;
    logic [srm_pkg::ID_BITS-1:0]        out_type_reg, out_type_next;
    logic [srm_pkg::ID_BITS-1:0]        out_snd_reg, out_snd_next;
    logic [srm_pkg::BODY_BITS-1:0]      out_body_reg, out_body_next;

    logic [srm_pkg::IDX_BITS-1:0]       cur_idx;
    logic [srm_pkg::IDX_BITS-1:0]       prev_idx;
    logic [srm_pkg::IDX_BITS-1:0]       slot_idx;
    logic [srm_pkg::PTR_BITS-1:0]       cur_link;
    logic [srm_pkg::TAG_BITS-1:0]       cur_tag;
    logic [srm_pkg::ID_BITS-1:0]        cur_type;
    logic [srm_pkg::ID_BITS-1:0]        cur_snd;
    logic                               exit_hit;

    // single read port on the slot store, always at the walk pointer
    assign cur_idx  = cur_reg[srm_pkg::IDX_BITS-1:0];
    assign prev_idx = prev_reg[srm_pkg::IDX_BITS-1:0];
    assign slot_idx = slot_reg[srm_pkg::IDX_BITS-1:0];
    assign cur_link = slot_link_reg[cur_idx];
    assign cur_tag  = slot_tag_reg[cur_idx];
    assign cur_type = cur_tag[srm_pkg::ID_BITS-1:0];
    assign cur_snd  = cur_tag[srm_pkg::TAG_BITS-1:srm_pkg::ID_BITS];

    assign exit_hit = (wait_reg == srm_pkg::WAIT_PENDING) && !fws_reg && (fsnd_reg == snd_reg);

    always_comb
    begin
        status.action     = act_reg;
        status.waiter_hit = (wait_reg == srm_pkg::WAIT_PENDING)
                            && (fwt_reg || (ftype_reg == type_reg))
                            && (fws_reg || (fsnd_reg == snd_reg));
        status.free_empty = !(free_head_reg < srm_pkg::SLOT_CNT);
        status.busy_empty = !(busy_head_reg < srm_pkg::SLOT_CNT);
        status.tail_done  = (cnt_reg == srm_pkg::SLOT_CNT) || !(cur_link < srm_pkg::SLOT_CNT);
        status.scan_end   = (cnt_reg == srm_pkg::SLOT_CNT) || !(cur_reg < srm_pkg::SLOT_CNT);
        status.scan_hit   = (wt_reg || (type_reg == cur_type)) && (ws_reg || (snd_reg == cur_snd));
        status.out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        act_next        = act_reg;
        type_next       = type_reg;
        snd_next        = snd_reg;
        body_next       = body_reg;
        wt_next         = wt_reg;
        ws_next         = ws_reg;
        free_head_next  = free_head_reg;
        busy_head_next  = busy_head_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        slot_next       = slot_reg;
        cnt_next        = cnt_reg;
        wait_next       = wait_reg;
        ftype_next      = ftype_reg;
        fsnd_next       = fsnd_reg;
        fwt_next        = fwt_reg;
        fws_next        = fws_reg;
        slot_link_next  = slot_link_reg;
        res_status_next = res_status_reg;
        res_has_next    = res_has_reg;
        res_type_next   = res_type_reg;
        res_snd_next    = res_snd_reg;
        res_body_next   = res_body_reg;
        out_status_next = out_status_reg;
        out_has_next    = out_has_reg;
        out_type_next   = out_type_reg;
        out_snd_next    = out_snd_reg;
        out_body_next   = out_body_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        case (op)
            srm_pkg::OP_LOAD:
            begin
                act_next  = srm_pkg::act_t'(in_user);
                type_next = in_data[srm_pkg::ID_BITS-1:0];
                snd_next  = in_data[srm_pkg::TAG_BITS-1:srm_pkg::ID_BITS];
                body_next = in_data[srm_pkg::IN_BODY_LSB +: srm_pkg::BODY_BITS];
                wt_next   = in_data[srm_pkg::IN_WT_BIT];
                ws_next   = in_data[srm_pkg::IN_WS_BIT];
                // park the read port on the free head for an allocation
                cur_next  = free_head_reg;
            end
            srm_pkg::OP_HANDOVER:
            begin
                wait_next       = srm_pkg::WAIT_FILLED;
                res_status_next = srm_pkg::ST_HANDED;
                res_has_next    = 1'b1;
                res_type_next   = type_reg;
                res_snd_next    = snd_reg;
                res_body_next   = body_reg;
            end
            srm_pkg::OP_FULL:
            begin
                res_status_next = srm_pkg::ST_FULL;
                res_has_next    = 1'b0;
                res_type_next   = '0;
                res_snd_next    = '0;
                res_body_next   = '0;
            end
            srm_pkg::OP_ALLOC:
            begin
                free_head_next          = cur_link;
                slot_link_next[cur_idx] = srm_pkg::NIL;
                slot_next               = cur_reg;
                if (!(busy_head_reg < srm_pkg::SLOT_CNT))
                begin
                    busy_head_next = cur_reg;
                end
                cur_next        = busy_head_reg;
                cnt_next        = '0;
                res_status_next = srm_pkg::ST_QUEUED;
                res_has_next    = 1'b0;
                res_type_next   = '0;
                res_snd_next    = '0;
                res_body_next   = '0;
            end
            srm_pkg::OP_TAIL_STEP:
            begin
                cur_next = cur_link;
                cnt_next = cnt_reg + 1'b1;
            end
            srm_pkg::OP_TAIL_LINK:
            begin
                if (cur_link < srm_pkg::SLOT_CNT)
                begin
                    slot_link_next[slot_idx] = cur_link;
                end
                slot_link_next[cur_idx] = slot_reg;
            end
            srm_pkg::OP_SCAN_START:
            begin
                cur_next  = busy_head_reg;
                prev_next = srm_pkg::NIL;
                cnt_next  = '0;
            end
            srm_pkg::OP_SCAN_STEP:
            begin
                prev_next = cur_reg;
                cur_next  = cur_link;
                cnt_next  = cnt_reg + 1'b1;
            end
            srm_pkg::OP_TAKE:
            begin
                if (!(prev_reg < srm_pkg::SLOT_CNT))
                begin
                    busy_head_next = cur_link;
                end
                else
                begin
                    slot_link_next[prev_idx] = cur_link;
                end
                slot_link_next[cur_idx] = free_head_reg;
                free_head_next          = cur_reg;
                res_status_next         = srm_pkg::ST_RECEIVED;
                res_has_next            = 1'b1;
                res_type_next           = cur_type;
                res_snd_next            = cur_snd;
                res_body_next           = slot_body_reg[cur_idx];
            end
            srm_pkg::OP_PEND:
            begin
                wait_next       = srm_pkg::WAIT_PENDING;
                ftype_next      = type_reg;
                fsnd_next       = snd_reg;
                fwt_next        = wt_reg;
                fws_next        = ws_reg;
                res_status_next = srm_pkg::ST_WAITING;
                res_has_next    = 1'b0;
                res_type_next   = '0;
                res_snd_next    = '0;
                res_body_next   = '0;
            end
            srm_pkg::OP_CLEAR:
            begin
                wait_next       = srm_pkg::WAIT_NONE;
                res_status_next = srm_pkg::ST_NO_EFFECT;
                res_has_next    = 1'b0;
                res_type_next   = '0;
                res_snd_next    = '0;
                res_body_next   = '0;
            end
            srm_pkg::OP_EXIT:
            begin
                if (exit_hit)
                begin
                    wait_next       = srm_pkg::WAIT_NONE;
                    res_status_next = srm_pkg::ST_FAILED;
                end
                else
                begin
                    res_status_next = srm_pkg::ST_NO_EFFECT;
                end
                res_has_next  = 1'b0;
                res_type_next = '0;
                res_snd_next  = '0;
                res_body_next = '0;
            end
            srm_pkg::OP_EMIT:
            begin
                out_valid_next  = 1'b1;
                out_status_next = res_status_reg;
                out_has_next    = res_has_reg;
                out_type_next   = res_type_reg;
                out_snd_next    = res_snd_reg;
                out_body_next   = res_body_reg;
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= '0;
            busy_head_reg <= srm_pkg::NIL;
            wait_reg      <= srm_pkg::WAIT_NONE;
            ftype_reg     <= '0;
            fsnd_reg      <= '0;
            fwt_reg       <= 1'b0;
            fws_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < srm_pkg::SLOTS; i++)
            begin
                slot_link_reg[i] <= (i == srm_pkg::SLOTS - 1) ? srm_pkg::NIL
                                                              : srm_pkg::PTR_BITS'(i + 1);
            end
        end
        else
        begin
            free_head_reg <= free_head_next;
            busy_head_reg <= busy_head_next;
            wait_reg      <= wait_next;
            ftype_reg     <= ftype_next;
            fsnd_reg      <= fsnd_next;
            fwt_reg       <= fwt_next;
            fws_reg       <= fws_next;
            out_valid_reg <= out_valid_next;
            slot_link_reg <= slot_link_next;
        end
    end

    // payload and walk registers
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        type_reg       <= type_next;
        snd_reg        <= snd_next;
        body_reg       <= body_next;
        wt_reg         <= wt_next;
        ws_reg         <= ws_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        slot_reg       <= slot_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_has_reg    <= res_has_next;
        res_type_reg   <= res_type_next;
        res_snd_reg    <= res_snd_next;
        res_body_reg   <= res_body_next;
        out_status_reg <= out_status_next;
        out_has_reg    <= out_has_next;
        out_type_reg   <= out_type_next;
        out_snd_reg    <= out_snd_next;
        out_body_reg   <= out_body_next;
    end

    // message store, written at the free head on allocation
    always_ff @(posedge clk)
    begin
        if (op == srm_pkg::OP_ALLOC)
        begin
            slot_body_reg[cur_idx] <= body_reg;
            slot_tag_reg[cur_idx]  <= {snd_reg, type_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{srm_pkg::OUT_PAD_BITS{1'b0}}, out_body_reg, out_snd_reg, out_type_reg};
    assign out_user  = {out_has_reg, out_status_reg};

endmodule

[rtl/core/srm_ctrl.sv]
module srm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  srm_pkg::dp_status_t status,
    output srm_pkg::dp_op_t     op
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_TAIL   = 5'b00100,
        S_SCAN   = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op         = srm_pkg::OP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = srm_pkg::OP_LOAD;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (status.action)
                    srm_pkg::ACT_DELIVER:
                    begin
                        if (status.waiter_hit)
                        begin
                            op         = srm_pkg::OP_HANDOVER;
                            state_next = S_EMIT;
                        end
                        else if (status.free_empty)
                        begin
                            op         = srm_pkg::OP_FULL;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            op         = srm_pkg::OP_ALLOC;
                            state_next = status.busy_empty ? S_EMIT : S_TAIL;
                        end
                    end
                    srm_pkg::ACT_RECEIVE:
                    begin
                        op         = srm_pkg::OP_SCAN_START;
                        state_next = S_SCAN;
                    end
                    srm_pkg::ACT_CLEAR:
                    begin
                        op         = srm_pkg::OP_CLEAR;
                        state_next = S_EMIT;
                    end
                    default:
                    begin
                        op         = srm_pkg::OP_EXIT;
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_TAIL:
            begin
                if (status.tail_done)
                begin
                    op         = srm_pkg::OP_TAIL_LINK;
                    state_next = S_EMIT;
                end
                else
                begin
                    op = srm_pkg::OP_TAIL_STEP;
                end
            end
            S_SCAN:
            begin
                if (status.scan_end)
                begin
                    op         = srm_pkg::OP_PEND;
                    state_next = S_EMIT;
                end
                else if (status.scan_hit)
                begin
                    op         = srm_pkg::OP_TAKE;
                    state_next = S_EMIT;
                end
                else
                begin
                    op = srm_pkg::OP_SCAN_STEP;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    op         = srm_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/srm_checker.sv]
module srm_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [srm_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    input  logic [srm_pkg::OUT_USER_BITS-1:0]   m_axis_tuser
);

    logic                               has_msg;
    logic [srm_pkg::STATUS_BITS-1:0]    st;

    assign has_msg = m_axis_tuser[srm_pkg::STATUS_BITS];
    assign st      = m_axis_tuser[srm_pkg::STATUS_BITS-1:0];

    // once reset has been seen at an edge the block is empty and ready
    a_reset_state: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("reset state wrong");

    // one transaction in flight
    a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transaction taken while busy");

    // a message only comes with handover or receive
    a_msg_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && has_msg |-> st == srm_pkg::ST_HANDED || st == srm_pkg::ST_RECEIVED)
        else $error("message with wrong status");

    // no message means zero fields
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !has_msg |-> m_axis_tdata == '0)
        else $error("fields not cleared without message");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind selective_receive_mailbox_unit srm_checker u_srm_checker (.*);

[tb/sv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import srm_pkg::*;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 250;
    localparam int LONG_HOLD     = 400;

    // one transaction towards the mailbox
    typedef struct packed {
        act_t                 action;
        logic [ID_BITS-1:0]   msg_type;
        logic [ID_BITS-1:0]   sender;
        logic [BODY_BITS-1:0] payload;
        logic                 any_type;
        logic                 any_sender;
    } mail_req_t;

    // one result from the mailbox
    typedef struct packed {
        status_t              status;
        logic                 has_message;
        logic [ID_BITS-1:0]   out_type;
        logic [ID_BITS-1:0]   out_sender;
        logic [BODY_BITS-1:0] out_payload;
    } mail_rsp_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    // msg_type, sender, payload, any_type, any_sender, zero pad
    logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
    // action
    logic [ACT_BITS-1:0]      s_axis_tuser = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // out_type, out_sender, out_payload
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    // status, has_message
    logic [OUT_USER_BITS-1:0] m_axis_tuser;

    selective_receive_mailbox_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // mirror of the mailbox contents
    logic [BODY_BITS-1:0] slot_payload [SLOTS];
    logic [ID_BITS-1:0]   slot_type [SLOTS];
    logic [ID_BITS-1:0]   slot_from [SLOTS];
    logic [PTR_BITS-1:0]  slot_link [SLOTS];
    logic [PTR_BITS-1:0]  free_first;
    logic [PTR_BITS-1:0]  busy_first;
    wait_t                rcv_state;
    logic [ID_BITS-1:0]   rcv_type;
    logic [ID_BITS-1:0]   rcv_from;
    logic                 rcv_any_type;
    logic                 rcv_any_from;

    mail_req_t mail_todo_q [$];
    mail_rsp_t answer_q [$];

    mail_req_t            drv_req;
    logic [IN_DATA_BITS-1:0] drv_word;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    int hold_req = 0;
    int hold_ack = 0;
    bit send_idle_on = 1'b0;
    bit recv_idle_on = 1'b0;
    int err_cnt = 0;
    int sent_cnt = 0;
    int cycle_cnt = 0;
    int status_tally [8];

    function automatic logic id_match(input logic [ID_BITS-1:0] want_type,
                                      input logic [ID_BITS-1:0] want_from,
                                      input logic any_t, input logic any_s,
                                      input logic [ID_BITS-1:0] msg_t,
                                      input logic [ID_BITS-1:0] msg_s);
        return (any_t || want_type == msg_t) && (any_s || want_from == msg_s);
    endfunction

    // applies one transaction to the mirror and returns the result it must give
    function automatic mail_rsp_t mailbox_answer(input mail_req_t req);
        mail_rsp_t           rsp;
        logic [PTR_BITS-1:0] slot;
        logic [PTR_BITS-1:0] cur;
        logic [PTR_BITS-1:0] prev;
        logic                found;
        int                  n;
        rsp = '0;
        rsp.status = ST_NO_EFFECT;
        case (req.action)
            ACT_DELIVER: begin
                if (rcv_state == WAIT_PENDING &&
                    id_match(rcv_type, rcv_from, rcv_any_type, rcv_any_from,
                             req.msg_type, req.sender)) begin
                    // straight to the waiting receive, nothing stored
                    rcv_state = WAIT_FILLED;
                    rsp.status = ST_HANDED;
                    rsp.has_message = 1'b1;
                    rsp.out_type = req.msg_type;
                    rsp.out_sender = req.sender;
                    rsp.out_payload = req.payload;
                end
                else if (free_first >= SLOT_CNT) begin
                    rsp.status = ST_FULL;
                end
                else begin
                    slot = free_first;
                    slot_payload[slot] = req.payload;
                    slot_type[slot] = req.msg_type;
                    slot_from[slot] = req.sender;
                    free_first = slot_link[slot];
                    slot_link[slot] = NIL;
                    if (busy_first >= SLOT_CNT) begin
                        busy_first = slot;
                    end
                    else begin
                        // walk to the tail, bounded in case of a broken chain
                        cur = busy_first;
                        for (n = 0; n < SLOTS && slot_link[cur] < SLOT_CNT; n++)
                            cur = slot_link[cur];
                        if (slot_link[cur] < SLOT_CNT)
                            slot_link[slot] = slot_link[cur];
                        slot_link[cur] = slot;
                    end
                    rsp.status = ST_QUEUED;
                end
            end
            ACT_RECEIVE: begin
                prev = NIL;
                cur = busy_first;
                found = 1'b0;
                for (n = 0; n < SLOTS && cur < SLOT_CNT && !found; n++) begin
                    if (id_match(req.msg_type, req.sender, req.any_type, req.any_sender,
                                 slot_type[cur], slot_from[cur])) begin
                        found = 1'b1;
                        rsp.status = ST_RECEIVED;
                        rsp.has_message = 1'b1;
                        rsp.out_type = slot_type[cur];
                        rsp.out_sender = slot_from[cur];
                        rsp.out_payload = slot_payload[cur];
                        // unlink and push the slot onto the free list
                        if (prev >= SLOT_CNT)
                            busy_first = slot_link[cur];
                        else
                            slot_link[prev] = slot_link[cur];
                        slot_link[cur] = free_first;
                        free_first = cur;
                    end
                    else begin
                        prev = cur;
                        cur = slot_link[cur];
                    end
                end
                if (!found) begin
                    rcv_state = WAIT_PENDING;
                    rcv_type = req.msg_type;
                    rcv_from = req.sender;
                    rcv_any_type = req.any_type;
                    rcv_any_from = req.any_sender;
                    rsp.status = ST_WAITING;
                end
            end
            ACT_CLEAR: begin
                rcv_state = WAIT_NONE;
            end
            default: begin
                // only a receive waiting on exactly this sender fails
                if (rcv_state == WAIT_PENDING && !rcv_any_from && rcv_from == req.sender) begin
                    rcv_state = WAIT_NONE;
                    rsp.status = ST_FAILED;
                end
            end
        endcase
        return rsp;
    endfunction

    function automatic mail_req_t mail_req(input act_t act, input logic [7:0] t,
                                           input logic [7:0] s, input logic [63:0] p,
                                           input logic wt, input logic ws);
        mail_req_t r;
        r.action = act;
        r.msg_type = t;
        r.sender = s;
        r.payload = p;
        r.any_type = wt;
        r.any_sender = ws;
        return r;
    endfunction

    // mostly a small set of ids so that filters hit, sometimes the full range
    function automatic logic [ID_BITS-1:0] pick_id();
        if ($urandom_range(0, 99) < 80)
            return ID_BITS'($urandom_range(0, 3));
        return ID_BITS'($urandom_range(0, (1 << ID_BITS) - 1));
    endfunction

    function automatic mail_req_t random_request(input int deliver_pct);
        mail_req_t r;
        int        pick;
        pick = $urandom_range(0, 99);
        r.action = (pick < deliver_pct) ? ACT_DELIVER :
                   (pick < 88) ? ACT_RECEIVE :
                   (pick < 94) ? ACT_CLEAR : ACT_EXIT;
        r.msg_type = pick_id();
        r.sender = pick_id();
        r.payload = {$urandom, $urandom};
        r.any_type = ($urandom_range(0, 99) < 25);
        r.any_sender = ($urandom_range(0, 99) < 25);
        return r;
    endfunction

    // idle length: mostly short, now and then long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            return $urandom_range(1, 3);
        if (pick < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic compare_field(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
            err_cnt++;
        end
    endtask

    // sender: predicts at acceptance, then loads the next transaction or idles
    always @(posedge clk) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
        end
        else begin
            if (s_axis_tvalid && s_axis_tready) begin
                answer_q.push_back(mailbox_answer(drv_req));
                sent_cnt++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (mail_todo_q.size() > 0) begin
                    drv_req = mail_todo_q.pop_front();
                    drv_word = '0;
                    drv_word[ID_BITS-1:0] = drv_req.msg_type;
                    drv_word[TAG_BITS-1:ID_BITS] = drv_req.sender;
                    drv_word[IN_BODY_LSB +: BODY_BITS] = drv_req.payload;
                    drv_word[IN_WT_BIT] = drv_req.any_type;
                    drv_word[IN_WS_BIT] = drv_req.any_sender;
                    s_axis_tdata <= drv_word;
                    s_axis_tuser <= drv_req.action;
                    s_axis_tvalid <= 1'b1;
                    if (send_idle_on && $urandom_range(0, 99) < 30)
                        send_gap = idle_len();
                end
                else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver readiness: random stalls plus a long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            hold_left = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (recv_gap > 0) begin
            recv_gap--;
            m_axis_tready <= 1'b0;
        end
        else begin
            m_axis_tready <= 1'b1;
            if (recv_idle_on && $urandom_range(0, 99) < 15)
                recv_gap = idle_len();
        end
    end

    // result checker
    always @(posedge clk) begin
        mail_rsp_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual tuser %0h tdata %0h",
                         $time, m_axis_tuser, m_axis_tdata);
                err_cnt++;
            end
            else begin
                want = answer_q.pop_front();
                compare_field("status", 64'(want.status), 64'(m_axis_tuser[STATUS_BITS-1:0]));
                compare_field("has_message", 64'(want.has_message),
                              64'(m_axis_tuser[STATUS_BITS]));
                compare_field("out_type", 64'(want.out_type), 64'(m_axis_tdata[ID_BITS-1:0]));
                compare_field("out_sender", 64'(want.out_sender),
                              64'(m_axis_tdata[TAG_BITS-1:ID_BITS]));
                compare_field("out_payload", 64'(want.out_payload),
                              64'(m_axis_tdata[TAG_BITS +: BODY_BITS]));
                status_tally[int'(want.status)]++;
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, answer_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // holds the sender back until every expected result has come
    task automatic wait_all_answered();
        @(negedge clk);
        while (mail_todo_q.size() != 0 || s_axis_tvalid || answer_q.size() != 0)
            @(negedge clk);
    endtask

    initial begin
        int phase;
        int i;
        int deliver_pct;
        for (i = 0; i < 8; i++)
            status_tally[i] = 0;
        for (i = 0; i < SLOTS; i++)
            slot_link[i] = PTR_BITS'(i + 1);
        slot_link[SLOTS-1] = NIL;
        free_first = '0;
        busy_first = NIL;
        rcv_state = WAIT_NONE;
        rcv_type = '0;
        rcv_from = '0;
        rcv_any_type = 1'b0;
        rcv_any_from = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty store, handover, filled waiter, exit rules, full store
        mail_todo_q.push_back(mail_req(ACT_RECEIVE, 8'h00, 8'h00, 64'h0, 1'b1, 1'b1));
        mail_todo_q.push_back(mail_req(ACT_CLEAR, 8'h00, 8'h00, 64'h0, 1'b0, 1'b0));
        mail_todo_q.push_back(mail_req(ACT_EXIT, 8'h00, 8'h00, 64'h0, 1'b0, 1'b0));
        mail_todo_q.push_back(mail_req(ACT_DELIVER, 8'h00, 8'h00, 64'h0, 1'b0, 1'b0));
        mail_todo_q.push_back(mail_req(ACT_DELIVER, 8'hFF, 8'hFF, '1, 1'b1, 1'b1));
        mail_todo_q.push_back(mail_req(ACT_RECEIVE, 8'hFF, 8'hFF, '1, 1'b0, 1'b0));
        mail_todo_q.push_back(mail_req(ACT_RECEIVE, 8'h12, 8'h34, 64'h0, 1'b0, 1'b0));
        mail_todo_q.push_back(mail_req(ACT_DELIVER, 8'h12, 8'h35, 64'hA5A5_0000_FFFF_5A5A,
                                       1'b0, 1'b0));
        mail_todo_q.push_back(mail_req(ACT_DELIVER, 8'h12, 8'h34, 64'h0123_4567_89AB_CDEF,
                                       1'b0, 1'b0));
        mail_todo_q.push_back(mail_req(ACT_DELIVER, 8'h12, 8'h34, 64'hFEDC_BA98_7654_3210,
                                       1'b0, 1'b0));
        mail_todo_q.push_back(mail_req(ACT_RECEIVE, 8'h99, 8'h34, 64'h0, 1'b1, 1'b0));
        mail_todo_q.push_back(mail_req(ACT_RECEIVE, 8'h77, 8'h99, 64'h0, 1'b0, 1'b0));
        mail_todo_q.push_back(mail_req(ACT_EXIT, 8'h77, 8'h98, 64'h0, 1'b0, 1'b0));
        mail_todo_q.push_back(mail_req(ACT_EXIT, 8'h77, 8'h99, 64'h0, 1'b0, 1'b0));
        mail_todo_q.push_back(mail_req(ACT_RECEIVE, 8'h55, 8'h00, 64'h0, 1'b0, 1'b1));
        mail_todo_q.push_back(mail_req(ACT_EXIT, 8'h00, 8'h55, 64'h0, 1'b0, 1'b0));
        mail_todo_q.push_back(mail_req(ACT_CLEAR, 8'hFF, 8'hFF, '1, 1'b1, 1'b1));
        for (i = 0; i < SLOTS - 1; i++)
            mail_todo_q.push_back(mail_req(ACT_DELIVER, 8'(i + 1), 8'(8'hF0 + i),
                                           {$urandom, $urandom}, 1'b0, 1'b0));
        mail_todo_q.push_back(mail_req(ACT_RECEIVE, 8'h00, 8'hF3, 64'h0, 1'b1, 1'b0));
        mail_todo_q.push_back(mail_req(ACT_RECEIVE, 8'h00, 8'h00, 64'h0, 1'b1, 1'b1));
        wait_all_answered();

        // random phases with changing mix and idling, and a long output hold-off in phases 2 and 5
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            send_idle_on = (phase % 3 != 2);
            recv_idle_on = (phase % 3 != 1);
            deliver_pct = (phase == 1 || phase == 5) ? 70 : (phase == 4) ? 25 : 45;
            if (phase == 2 || phase == 5)
                hold_req++;
            for (i = 0; i < PHASE_ITEMS; i++)
                mail_todo_q.push_back(random_request(deliver_pct));
            wait_all_answered();
        end

        repeat (SLOTS + 8) @(negedge clk);
        $display("%0d transactions: %0d queued, %0d handed to a waiting receive, %0d refused full",
                 sent_cnt, status_tally[int'(ST_QUEUED)], status_tally[int'(ST_HANDED)],
                 status_tally[int'(ST_FULL)]);
        $display("%0d received, %0d left waiting, %0d waits failed by exit, %0d without effect",
                 status_tally[int'(ST_RECEIVED)], status_tally[int'(ST_WAITING)],
                 status_tally[int'(ST_FAILED)], status_tally[int'(ST_NO_EFFECT)]);
        if (err_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
rtl/core/srm_pkg.sv
rtl/core/srm_datapath.sv
rtl/core/srm_ctrl.sv
rtl/core/selective_receive_mailbox_unit.sv
rtl/core/srm_checker.sv
tb/sv/tb_top.sv
